@@ src/bmprle8_pkg.sv @@
// Shared types and constants for the RLE8 bitmap stream decoder.
// Used by every module of the block; depends on nothing else.
package bmprle8_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_DIMENSION);
    localparam logic [DIM_W-1:0] POS_MAX = '1;

    // escape codes following a zero byte
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    // register indexes on the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_ESCAPE,
        PH_DELTA_X,
        PH_DELTA_Y,
        PH_LITERAL,
        PH_PAD,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        TOK_RUN,
        TOK_EOL,
        TOK_EOB,
        TOK_DELTA,
        TOK_LIT_START,
        TOK_LIT_BYTE
    } tok_kind_t;

    // a: run count, literal count or delta x; b: pixel value or delta y
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] a;
        logic [7:0] b;
    } token_t;

    typedef struct packed {
        logic [11:0] frame_row;
        logic [11:0] frame_column;
        logic [7:0]  segment_length;
        logic [7:0]  pixel_value;
        logic        image_done;
    } result_t;

endpackage

@@ src/bmprle8_parser.sv @@
// Front end: walks the byte grammar of the RLE8 stream and issues tokens.
// Depends on bmprle8_pkg.
module bmprle8_parser
    import bmprle8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    output logic       tok_valid,
    output token_t     tok
);

    phase_t     phase_reg, phase_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] left_reg, left_next;
    logic       pad_reg, pad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            pending_reg <= '0;
            left_reg    <= '0;
            pad_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            left_reg    <= left_next;
            pad_reg     <= pad_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        left_next    = left_reg;
        pad_next     = pad_reg;
        tok_valid    = 1'b0;
        tok.kind     = TOK_RUN;
        tok.a        = pending_reg;
        tok.b        = data_byte;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    if (data_byte != 8'd0)
                    begin
                        pending_next = data_byte;
                        phase_next   = PH_VALUE;
                    end
                    else
                    begin
                        phase_next = PH_ESCAPE;
                    end
                end
                PH_VALUE:
                begin
                    tok_valid  = 1'b1;
                    tok.kind   = TOK_RUN;
                    phase_next = PH_COUNT;
                end
                PH_ESCAPE:
                begin
                    unique case (data_byte)
                        ESC_EOL:
                        begin
                            tok_valid  = 1'b1;
                            tok.kind   = TOK_EOL;
                            phase_next = PH_COUNT;
                        end
                        ESC_EOB:
                        begin
                            tok_valid  = 1'b1;
                            tok.kind   = TOK_EOB;
                            phase_next = PH_DONE;
                        end
                        ESC_DELTA:
                        begin
                            phase_next = PH_DELTA_X;
                        end
                        default:
                        begin
                            // absolute run: pad byte follows when the count is odd
                            tok_valid  = 1'b1;
                            tok.kind   = TOK_LIT_START;
                            tok.a      = data_byte;
                            left_next  = data_byte;
                            pad_next   = data_byte[0];
                            phase_next = PH_LITERAL;
                        end
                    endcase
                end
                PH_DELTA_X:
                begin
                    pending_next = data_byte;
                    phase_next   = PH_DELTA_Y;
                end
                PH_DELTA_Y:
                begin
                    tok_valid  = 1'b1;
                    tok.kind   = TOK_DELTA;
                    phase_next = PH_COUNT;
                end
                PH_LITERAL:
                begin
                    tok_valid = 1'b1;
                    tok.kind  = TOK_LIT_BYTE;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = pad_reg ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_COUNT;
                end
                PH_DONE:
                begin
                    // drop everything until reset
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

endmodule

@@ src/bmprle8_queue.sv @@
// Short token queue between the parser and the segment writer.
// Depends on bmprle8_pkg.
module bmprle8_queue
    import bmprle8_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_tok,
    output logic   full,
    output logic   head_valid,
    output token_t head_tok,
    input  logic   pop
);

    token_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_tok   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("token pushed into a full queue");

endmodule

@@ src/bmprle8_writer.sv @@
// Back end: applies tokens to the cursor, checks bounds and forms segments.
// Depends on bmprle8_pkg.
module bmprle8_writer
    import bmprle8_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    input  logic             tok_valid,
    input  token_t           tok,
    output logic             tok_pop,
    output logic             res_valid,
    output result_t          res,
    input  logic             res_ready
);

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] line_reg, line_next;
    logic             skip_reg, skip_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic [DIM_W-1:0] eff_w, eff_h;
    logic             out_free, emit;
    logic             run_oob;
    logic [DIM_W-1:0] row_full;

    function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] p,
                                                 input logic [7:0]       d);
        logic [DIM_W:0] s;
        s = {1'b0, p} + {{(DIM_W-7){1'b0}}, d};
        return s[DIM_W] ? POS_MAX : s[DIM_W-1:0];
    endfunction

    assign eff_w    = (image_width > MAX_DIM) ? MAX_DIM : image_width;
    assign eff_h    = (image_height > MAX_DIM) ? MAX_DIM : image_height;
    assign out_free = !out_valid_reg || res_ready;
    assign tok_pop  = tok_valid && out_free;
    assign row_full = eff_h - DIM_W'(1) - line_reg;

    // bound test shared by encoded runs and the start of absolute runs
    assign run_oob = (({1'b0, col_reg} + {{(DIM_W-7){1'b0}}, tok.a}) > {1'b0, eff_w})
                     || (line_reg >= eff_h);

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        skip_next = skip_reg;
        emit      = 1'b0;
        out_next  = out_reg;
        if (tok_pop)
        begin
            out_next.frame_row      = row_full[11:0];
            out_next.frame_column   = col_reg[11:0];
            out_next.segment_length = tok.a;
            out_next.pixel_value    = tok.b;
            out_next.image_done     = 1'b0;
            unique case (tok.kind)
                TOK_RUN:
                begin
                    if (!run_oob)
                    begin
                        emit     = 1'b1;
                        col_next = sat_add(col_reg, tok.a);
                    end
                end
                TOK_EOL:
                begin
                    col_next  = '0;
                    line_next = sat_add(line_reg, 8'd1);
                end
                TOK_EOB:
                begin
                    emit     = 1'b1;
                    out_next = '0;
                    out_next.image_done = 1'b1;
                end
                TOK_DELTA:
                begin
                    col_next  = sat_add(col_reg, tok.a);
                    line_next = sat_add(line_reg, tok.b);
                end
                TOK_LIT_START:
                begin
                    skip_next = run_oob;
                end
                TOK_LIT_BYTE:
                begin
                    out_next.segment_length = 8'd1;
                    if (!skip_reg)
                    begin
                        emit     = 1'b1;
                        col_next = sat_add(col_reg, 8'd1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            line_reg      <= line_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.image_done |-> out_reg.segment_length == 8'd0)
        else $error("done marker carries a segment");

    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.image_done |-> out_reg.segment_length != 8'd0)
        else $error("empty pixel segment");

    a_cursor_moves: assert property (@(posedge clk) disable iff (!rst_n)
        emit && tok.kind == TOK_RUN |=>
            col_reg == sat_add($past(col_reg), $past(tok.a)))
        else $error("cursor did not advance by the run length");

endmodule

@@ src/bmprle8_decoder.sv @@
// Top level of the RLE8 bitmap stream decoder: APB registers and the
// parser, token queue and segment writer. Depends on bmprle8_pkg.
//
// Usage:
//  - s_tvalid/s_tready/s_tdata carry the compressed pixel stream, one byte
//    per transaction. m_tvalid/m_tready/m_tdata/m_tuser carry write
//    segments (row, column, length, value); m_tuser marks the done marker.
//  - image_width (0x0) and image_height (0x4) are written over APB while
//    the stream is idle; both read back. Values above 4096 act as 4096.
//  - Throughput is one byte per cycle while s_tready is high. The parser
//    classifies each byte in the cycle it is accepted; the writer applies
//    one token per cycle from a four-entry queue while its output is free.
//    A segment's token is written into the queue and is then registered
//    in the output register, which drives m_tvalid.
//  - If m_tready is low while a result is held, the writer stops taking
//    tokens; the queue absorbs up to four tokens before s_tready drops.
//  - Reset clears the parser phase, cursor, queue and output valid; the
//    registers return to width 1 and height 1. Bytes after end of bitmap
//    are taken and dropped until the next reset.
module bmp_rle8_decoder
    import bmprle8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [11:0] frame_row, [23:12] frame_column,
                                   // [31:24] segment_length, [39:32] pixel_value
    output logic        m_tuser,   // [0] image_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             reg_wr;
    logic             accept;
    logic             p_tok_valid;
    token_t           p_tok;
    logic             q_full, q_head_valid, q_pop;
    token_t           q_head;
    result_t          res;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (reg_wr)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                width_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-DIM_W){1'b0}}, height_reg}
                                             : {{(32-DIM_W){1'b0}}, width_reg};

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    bmprle8_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept),
        .data_byte  (s_tdata),
        .tok_valid  (p_tok_valid),
        .tok        (p_tok)
    );

    bmprle8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (p_tok_valid),
        .push_tok   (p_tok),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_tok   (q_head),
        .pop        (q_pop)
    );

    bmprle8_writer u_writer (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .tok_valid    (q_head_valid),
        .tok          (q_head),
        .tok_pop      (q_pop),
        .res_valid    (m_tvalid),
        .res          (res),
        .res_ready    (m_tready)
    );

    assign m_tdata = {res.pixel_value, res.segment_length, res.frame_column, res.frame_row};
    assign m_tuser = res.image_done;

endmodule
